// ===== design/shsf_pkg.sv =====
// ----------------------------------------------------------------------------
// shsf_pkg
// Shared types, constants and helper functions for the stream header strip
// FIFO: phase and error codes, item kinds, ring and header sizes.
// ----------------------------------------------------------------------------
package shsf_pkg;

    localparam int RING_DEPTH   = 65536;
    localparam int HEADER_LIMIT = 1024;

    localparam int RING_AW  = $clog2(RING_DEPTH);
    localparam int PTR_W    = RING_AW + 1;
    localparam int HCNT_W   = $clog2(HEADER_LIMIT);
    localparam int FILL_W   = 17;
    localparam int CREDIT_W = 18;
    localparam int PLEN_W   = 16;
    localparam int MS_W     = 32;
    localparam int CFG_AW   = 2;
    localparam int CFG_DW   = 32;

    localparam logic [CREDIT_W-1:0] CREDIT_MAX = {CREDIT_W{1'b1}};
    localparam logic [HCNT_W-1:0]   HDR_LAST   = HCNT_W'(HEADER_LIMIT - 1);

    localparam logic [39:0] STATUS_TEXT = 40'h2032303020;   // " 200 "
    localparam logic [31:0] HDR_END     = 32'h0D0A0D0A;     // CR LF CR LF

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_HEADERS   = 3'd1,
        PH_BUFFERING = 3'd2,
        PH_STREAMING = 3'd3,
        PH_ERROR     = 3'd4
    } t_phase;

    typedef enum logic [2:0] {
        ERR_NONE     = 3'd0,
        ERR_HDR_LONG = 3'd1,
        ERR_REJECTED = 3'd2,
        ERR_OVERFLOW = 3'd3,
        ERR_STALLED  = 3'd4
    } t_err;

    typedef enum logic [2:0] {
        KIND_BYTE    = 3'd0,
        KIND_PKT_END = 3'd1,
        KIND_READ    = 3'd2,
        KIND_POLL    = 3'd3,
        KIND_RESTART = 3'd4,
        KIND_STOP    = 3'd5
    } t_kind;

    typedef enum logic [1:0] {
        CFG_PREBUF    = 2'd0,
        CFG_FLOW_HIGH = 2'd1,
        CFG_FLOW_LOW  = 2'd2,
        CFG_STALL_MS  = 2'd3
    } t_cfg_reg;

    // Result of one item, before the read data returns from the ring.
    typedef struct packed {
        t_phase              phase;
        t_err                error_code;
        logic                read_valid;
        logic [FILL_W-1:0]   fill_level;
        logic [CREDIT_W-1:0] credit_release;
    } t_result;

    // Access to the ring store for one item.
    typedef struct packed {
        logic               we;
        logic [RING_AW-1:0] waddr;
        logic [7:0]         wdata;
        logic               re;
        logic [RING_AW-1:0] raddr;
    } t_ram_req;

    function automatic logic [7:0] http_char(input logic [2:0] pos);
        logic [7:0] c;
        unique case (pos)
            3'd0:    c = 8'h48; // H
            3'd1:    c = 8'h54; // T
            3'd2:    c = 8'h54; // T
            3'd3:    c = 8'h50; // P
            3'd4:    c = 8'h2F; // /
            3'd5:    c = 8'h31; // 1
            3'd6:    c = 8'h2E; // .
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] icy_char(input logic [2:0] pos);
        logic [7:0] c;
        unique case (pos)
            3'd0:    c = 8'h49; // I
            3'd1:    c = 8'h43; // C
            3'd2:    c = 8'h59; // Y
            3'd3:    c = 8'h20; // space
            3'd4:    c = 8'h32; // 2
            3'd5:    c = 8'h30; // 0
            3'd6:    c = 8'h30; // 0
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// ===== design/shsf_ram.sv =====
// ----------------------------------------------------------------------------
// shsf_ram
// Simple dual-port synchronous RAM: one write port, one read port with
// registered read data. Read data holds while no read is enabled.
// ----------------------------------------------------------------------------
module shsf_ram #(
    parameter int DEPTH = 65536,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/shsf_ctrl.sv =====
// ----------------------------------------------------------------------------
// shsf_ctrl
// Session control: configuration registers, header parser, ring pointers,
// flow-control credit and stall detection. Each accepted word updates the
// registered state and issues at most one ring access.
// ----------------------------------------------------------------------------
module shsf_ctrl
    import shsf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CFG_AW-1:0] i_cfg_addr,
    input  logic [CFG_DW-1:0] i_cfg_wdata,
    input  logic              i_accept,
    input  logic [2:0]        i_kind,
    input  logic [7:0]        i_data_byte,
    input  logic [PLEN_W-1:0] i_packet_length,
    input  logic [MS_W-1:0]   i_now_ms,
    output t_ram_req          o_ram_req,
    output t_result           o_result
);

    logic [FILL_W-1:0]   r_prebuf;
    logic [FILL_W-1:0]   r_flow_high;
    logic [FILL_W-1:0]   r_flow_low;
    logic [MS_W-1:0]     r_stall_ms;

    t_phase              r_phase,     n_phase;
    t_err                r_error,     n_error;
    logic [PTR_W-1:0]    r_wp,        n_wp;
    logic [PTR_W-1:0]    r_rp,        n_rp;
    logic [CREDIT_W-1:0] r_withheld,  n_withheld;
    logic [HCNT_W-1:0]   r_hcnt,      n_hcnt;
    logic [39:0]         r_recent,    n_recent;
    logic                r_http_ok,   n_http_ok;
    logic                r_icy_ok,    n_icy_ok;
    logic                r_status,    n_status;
    logic                r_overflow,  n_overflow;
    logic [MS_W-1:0]     r_last_ms,   n_last_ms;

    t_kind               kind;
    logic                active;
    logic                body;
    logic [PTR_W-1:0]    fill;
    logic                full;
    logic                wr_body;
    logic                rd_ring;
    logic [CREDIT_W-1:0] credit;
    logic [CREDIT_W:0]   credit_sum;
    logic [MS_W-1:0]     idle_ms;
    logic [HCNT_W-1:0]   hcnt_inc;
    logic [39:0]         recent_sh;
    logic                http_ok_h;
    logic                icy_ok_h;
    logic                status_h;
    logic                pass;

    assign kind    = t_kind'(i_kind);
    assign active  = (r_phase == PH_HEADERS) || (r_phase == PH_BUFFERING)
                     || (r_phase == PH_STREAMING);
    assign body    = (r_phase == PH_BUFFERING) || (r_phase == PH_STREAMING);
    assign fill    = r_wp - r_rp;
    assign full    = fill[PTR_W-1];
    assign wr_body = i_accept && (kind == KIND_BYTE) && body && !full;
    assign rd_ring = i_accept && (kind == KIND_READ) && (fill != '0);

    assign credit_sum = {1'b0, r_withheld} + (CREDIT_W+1)'(i_packet_length);
    assign idle_ms    = i_now_ms - r_last_ms;

    // Header byte tracking, evaluated against the incoming byte.
    assign hcnt_inc  = r_hcnt + 1'b1;
    assign recent_sh = {r_recent[31:0], i_data_byte};
    assign http_ok_h = r_http_ok && !((r_hcnt < HCNT_W'(7))
                       && (i_data_byte != http_char(r_hcnt[2:0])));
    assign icy_ok_h  = r_icy_ok && !((r_hcnt < HCNT_W'(7))
                       && (i_data_byte != icy_char(r_hcnt[2:0])));
    assign status_h  = r_status || ((hcnt_inc >= HCNT_W'(5)) && (recent_sh == STATUS_TEXT));
    assign pass      = (hcnt_inc >= HCNT_W'(7))
                       && ((http_ok_h && status_h) || icy_ok_h);

    // Next state for one accepted word.
    always_comb begin
        n_phase    = r_phase;
        n_error    = r_error;
        n_wp       = r_wp;
        n_rp       = r_rp;
        n_withheld = r_withheld;
        n_hcnt     = r_hcnt;
        n_recent   = r_recent;
        n_http_ok  = r_http_ok;
        n_icy_ok   = r_icy_ok;
        n_status   = r_status;
        n_overflow = r_overflow;
        n_last_ms  = r_last_ms;
        credit     = '0;
        if (i_accept) begin
            unique case (kind)
                KIND_BYTE: begin
                    if (r_phase == PH_HEADERS) begin
                        if (r_hcnt >= HDR_LAST) begin
                            n_phase = PH_ERROR;
                            n_error = ERR_HDR_LONG;
                        end else begin
                            n_hcnt    = hcnt_inc;
                            n_recent  = recent_sh;
                            n_http_ok = http_ok_h;
                            n_icy_ok  = icy_ok_h;
                            n_status  = status_h;
                            if ((hcnt_inc >= HCNT_W'(4)) && (recent_sh[31:0] == HDR_END)) begin
                                if (pass) begin
                                    n_phase = PH_BUFFERING;
                                end else begin
                                    n_phase = PH_ERROR;
                                    n_error = ERR_REJECTED;
                                end
                            end
                        end
                    end else if (body) begin
                        if (full) begin
                            n_overflow = 1'b1;
                        end else begin
                            n_wp = r_wp + 1'b1;
                        end
                    end
                end
                KIND_PKT_END: begin
                    if (active) begin
                        n_withheld = credit_sum[CREDIT_W] ? CREDIT_MAX
                                                          : credit_sum[CREDIT_W-1:0];
                        if (fill < r_flow_high) begin
                            credit     = n_withheld;
                            n_withheld = '0;
                        end
                        n_last_ms = i_now_ms;
                        if (r_overflow) begin
                            n_overflow = 1'b0;
                            n_phase    = PH_ERROR;
                            n_error    = ERR_OVERFLOW;
                        end else if ((r_phase == PH_BUFFERING) && (fill >= r_prebuf)) begin
                            n_phase = PH_STREAMING;
                        end
                    end
                end
                KIND_READ: begin
                    if (fill != '0) begin
                        n_rp = r_rp + 1'b1;
                    end
                end
                KIND_POLL: begin
                    if (active) begin
                        if ((r_withheld != '0) && (fill <= r_flow_low)) begin
                            credit     = r_withheld;
                            n_withheld = '0;
                        end
                        if (body && (n_withheld == '0) && (idle_ms >= r_stall_ms)) begin
                            n_phase = PH_ERROR;
                            n_error = ERR_STALLED;
                        end
                    end
                end
                KIND_RESTART, KIND_STOP: begin
                    n_wp       = '0;
                    n_rp       = '0;
                    n_withheld = '0;
                    n_error    = ERR_NONE;
                    n_hcnt     = '0;
                    n_recent   = '0;
                    n_http_ok  = 1'b1;
                    n_icy_ok   = 1'b1;
                    n_status   = 1'b0;
                    n_overflow = 1'b0;
                    if (kind == KIND_RESTART) begin
                        n_last_ms = i_now_ms;
                        n_phase   = PH_HEADERS;
                    end else begin
                        n_phase = PH_IDLE;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Ring access and result of the word.
    always_comb begin
        o_ram_req.we    = wr_body;
        o_ram_req.waddr = r_wp[RING_AW-1:0];
        o_ram_req.wdata = i_data_byte;
        o_ram_req.re    = rd_ring;
        o_ram_req.raddr = r_rp[RING_AW-1:0];

        o_result.phase          = n_phase;
        o_result.error_code     = n_error;
        o_result.read_valid     = rd_ring;
        o_result.fill_level     = FILL_W'(n_wp - n_rp);
        o_result.credit_release = credit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prebuf    <= FILL_W'(32768);
            r_flow_high <= FILL_W'(49152);
            r_flow_low  <= FILL_W'(32768);
            r_stall_ms  <= MS_W'(7000);
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_addr))
                CFG_PREBUF:    r_prebuf    <= i_cfg_wdata[FILL_W-1:0];
                CFG_FLOW_HIGH: r_flow_high <= i_cfg_wdata[FILL_W-1:0];
                CFG_FLOW_LOW:  r_flow_low  <= i_cfg_wdata[FILL_W-1:0];
                CFG_STALL_MS:  r_stall_ms  <= i_cfg_wdata[MS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_error    <= ERR_NONE;
            r_wp       <= '0;
            r_rp       <= '0;
            r_withheld <= '0;
            r_hcnt     <= '0;
            r_recent   <= '0;
            r_http_ok  <= 1'b1;
            r_icy_ok   <= 1'b1;
            r_status   <= 1'b0;
            r_overflow <= 1'b0;
            r_last_ms  <= '0;
        end else begin
            r_phase    <= n_phase;
            r_error    <= n_error;
            r_wp       <= n_wp;
            r_rp       <= n_rp;
            r_withheld <= n_withheld;
            r_hcnt     <= n_hcnt;
            r_recent   <= n_recent;
            r_http_ok  <= n_http_ok;
            r_icy_ok   <= n_icy_ok;
            r_status   <= n_status;
            r_overflow <= n_overflow;
            r_last_ms  <= n_last_ms;
        end
    end

`ifndef SYNTHESIS
    // The ring never holds more than its depth.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fill <= PTR_W'(RING_DEPTH))
        else $error("ring fill level beyond depth");

    // An error code is held exactly while the session is in the error phase.
    a_error_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_ERROR) == (r_error != ERR_NONE))
        else $error("error code does not match phase");

    // A stop empties the ring and drops any withheld credit.
    a_stop_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && (kind == KIND_STOP)) |=>
            ((r_wp == r_rp) && (r_withheld == '0) && (r_phase == PH_IDLE)))
        else $error("stop left session state behind");
`endif

endmodule

// ===== design/shsf_out.sv =====
// ----------------------------------------------------------------------------
// shsf_out
// Result pipeline: a stage that waits for the ring read data, then the
// output register. The input side stalls only when both are full and the
// output is stalled.
// ----------------------------------------------------------------------------
module shsf_out
    import shsf_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  t_result             i_result,
    input  logic [7:0]          i_ram_rdata,
    input  logic                i_stall,
    output logic                o_busy,
    output logic                o_valid,
    output logic [2:0]          o_phase,
    output logic [2:0]          o_error_code,
    output logic                o_read_valid,
    output logic [7:0]          o_read_data,
    output logic [FILL_W-1:0]   o_fill_level,
    output logic [CREDIT_W-1:0] o_credit_release
);

    logic       r_s1_valid;
    t_result    r_s1;
    logic       r_o_valid;
    t_result    r_o;
    logic [7:0] r_o_data;
    logic       s1_adv;

    assign s1_adv = r_s1_valid && (!r_o_valid || !i_stall);
    assign o_busy = r_s1_valid && r_o_valid && i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (i_load) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_o_valid <= 1'b1;
            end else if (r_o_valid && !i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // The ring holds its read data until the next read, which cannot be
    // issued before this word moves on.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_s1 <= i_result;
        end
        if (s1_adv) begin
            r_o      <= r_s1;
            r_o_data <= r_s1.read_valid ? i_ram_rdata : 8'h00;
        end
    end

    assign o_valid          = r_o_valid;
    assign o_phase          = r_o.phase;
    assign o_error_code     = r_o.error_code;
    assign o_read_valid     = r_o.read_valid;
    assign o_read_data      = r_o_data;
    assign o_fill_level     = r_o.fill_level;
    assign o_credit_release = r_o.credit_release;

`ifndef SYNTHESIS
    // A word never enters the first stage while it is still occupied and blocked.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_adv) |-> !i_load)
        else $error("result stage overwritten");

    // A word waiting in the first stage is still there next cycle.
    a_s1_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_adv) |=> (r_s1_valid && $stable(r_s1)))
        else $error("blocked result word lost");
`endif

endmodule

// ===== design/stream_header_strip_fifo.sv =====
// A result word passes the result stage and output register after its input
// word is accepted. One word per cycle while o_stall is low; each word makes
// at most one access to the single-port-pair ring RAM, with registered reads.
// Reset (synchronous, active low) returns the session to idle, empties the
// ring, and loads the register defaults; ring contents are left as they are.
// ----------------------------------------------------------------------------
// stream_header_strip_fifo
// Strips and checks a response header, then buffers body bytes in a ring
// FIFO with watermark credit flow control and stall detection.
// ----------------------------------------------------------------------------
module stream_header_strip_fifo
    import shsf_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CFG_AW-1:0]   i_cfg_addr,
    input  logic [CFG_DW-1:0]   i_cfg_wdata,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [2:0]          i_kind,
    input  logic [7:0]          i_data_byte,
    input  logic [PLEN_W-1:0]   i_packet_length,
    input  logic [MS_W-1:0]     i_now_ms,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [2:0]          o_phase,
    output logic [2:0]          o_error_code,
    output logic                o_read_valid,
    output logic [7:0]          o_read_data,
    output logic [FILL_W-1:0]   o_fill_level,
    output logic [CREDIT_W-1:0] o_credit_release
);

    logic       accept;
    logic       busy;
    t_ram_req   ram_req;
    t_result    result;
    logic [7:0] ram_rdata;

    assign o_stall = busy;
    assign accept  = i_valid && !busy;

    shsf_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_accept       (accept),
        .i_kind         (i_kind),
        .i_data_byte    (i_data_byte),
        .i_packet_length(i_packet_length),
        .i_now_ms       (i_now_ms),
        .o_ram_req      (ram_req),
        .o_result       (result)
    );

    shsf_ram #(
        .DEPTH(RING_DEPTH),
        .WIDTH(8)
    ) u_ring (
        .i_clk  (i_clk),
        .i_we   (ram_req.we),
        .i_waddr(ram_req.waddr),
        .i_wdata(ram_req.wdata),
        .i_re   (ram_req.re),
        .i_raddr(ram_req.raddr),
        .o_rdata(ram_rdata)
    );

    shsf_out u_out (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_load          (accept),
        .i_result        (result),
        .i_ram_rdata     (ram_rdata),
        .i_stall         (i_stall),
        .o_busy          (busy),
        .o_valid         (o_valid),
        .o_phase         (o_phase),
        .o_error_code    (o_error_code),
        .o_read_valid    (o_read_valid),
        .o_read_data     (o_read_data),
        .o_fill_level    (o_fill_level),
        .o_credit_release(o_credit_release)
    );

endmodule
